/* design/tlc_pkg.sv */
package tlc_pkg;

  localparam int MAX_CENTERS = 16;
  localparam int IDX_W       = $clog2(MAX_CENTERS);
  localparam int CNT_W       = $clog2(MAX_CENTERS + 1);
  localparam int PIX_W       = 8;
  localparam int LABEL_W     = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED      = 1'd1;

  localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd0;
  localparam logic [PIX_W-1:0] SEED_RESET      = 8'd128;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic step;
    logic finish;
  } tlc_cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } tlc_status_t;

endpackage

/* design/tlc_ctrl.sv */
module tlc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tlc_pkg::tlc_status_t status,
  output tlc_pkg::tlc_cmd_t    cmd
);
  import tlc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!status.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.start  = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
      end
      ST_COMMIT: begin
        cmd.finish = !status.out_busy;
      end
      default: ;
    endcase
  end

endmodule

/* design/tlc_dp.sv */
module tlc_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tlc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tlc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [tlc_pkg::PIX_W-1:0]        in_pixel_value,
  input  logic                             in_frame_start,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tlc_pkg::LABEL_W-1:0]      out_cluster_label,
  output logic                             out_new_center,
  output logic                             out_table_full,
  input  tlc_pkg::tlc_cmd_t                cmd,
  output tlc_pkg::tlc_status_t             status
);
  import tlc_pkg::*;

  logic [PIX_W-1:0]   thr_r;
  logic [PIX_W-1:0]   seed_r;
  logic [PIX_W-1:0]   centers_r [MAX_CENTERS];
  logic [CNT_W-1:0]   count_r;
  logic [PIX_W-1:0]   pix_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   best_r;
  logic [PIX_W:0]     best_dist_r;
  logic               near_r;
  logic               out_valid_r;
  logic [LABEL_W-1:0] label_r;
  logic               new_r;
  logic               full_r;

  logic [PIX_W-1:0]   cur;
  logic [PIX_W-1:0]   gap;
  logic               wr_new;
  logic               all_far;

  assign cur     = centers_r[idx_r];
  assign gap     = (pix_r >= cur) ? (pix_r - cur) : (cur - pix_r);
  assign all_far = !near_r;
  assign wr_new  = all_far && (count_r < CNT_W'(MAX_CENTERS));

  assign status.last     = (CNT_W'(idx_r) == (count_r - CNT_W'(1)));
  assign status.out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THRESHOLD_RESET;
      seed_r  <= SEED_RESET;
      count_r <= CNT_W'(1);
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_THRESHOLD) begin
          thr_r <= cfg_wdata;
        end else if (cfg_index == REG_SEED) begin
          seed_r <= cfg_wdata;
        end
      end
      if (cmd.start && in_frame_start) begin
        count_r <= CNT_W'(1);
      end else if (cmd.finish && wr_new) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centers_r[0] <= SEED_RESET;
    end else begin
      if (cmd.start && in_frame_start) begin
        centers_r[0] <= seed_r;
      end
      if (cmd.finish && wr_new) begin
        centers_r[count_r[IDX_W-1:0]] <= pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pix_r       <= in_pixel_value;
      idx_r       <= '0;
      best_r      <= '0;
      best_dist_r <= '1;
      near_r      <= 1'b0;
    end else if (cmd.step) begin
      if (gap <= thr_r) begin
        near_r <= 1'b1;
      end
      if ({1'b0, gap} < best_dist_r) begin
        best_dist_r <= {1'b0, gap};
        best_r      <= idx_r;
      end
      if (!status.last) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      new_r  <= wr_new;
      full_r <= all_far && !wr_new;
      if (wr_new) begin
        label_r <= LABEL_W'(count_r);
      end else begin
        label_r <= LABEL_W'(best_r);
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cluster_label = label_r;
  assign out_new_center    = new_r;
  assign out_table_full    = full_r;

endmodule

/* design/threshold_leader_clustering.sv */
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_we                 cfg_index, cfg_wdata
// in        in         in_valid / in_ready    in_pixel_value, in_frame_start
// out       out        out_valid / out_ready  out_cluster_label, out_new_center, out_table_full
//
// A request is loaded, then scanned against each stored center in turn through a single
// distance comparator, and then its result is committed.
// Synchronous reset loads threshold 0, seed 128, center zero with the seed and a count of one.
// The result sits in an output register; a new request is taken while it waits,
// and the commit cycle holds until that register is free.
module threshold_leader_clustering (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tlc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tlc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tlc_pkg::PIX_W-1:0]        in_pixel_value,
  input  logic                             in_frame_start,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tlc_pkg::LABEL_W-1:0]      out_cluster_label,
  output logic                             out_new_center,
  output logic                             out_table_full
);
  import tlc_pkg::*;

  tlc_cmd_t    cmd;
  tlc_status_t status;

  tlc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tlc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_pixel_value    (in_pixel_value),
    .in_frame_start    (in_frame_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cluster_label (out_cluster_label),
    .out_new_center    (out_new_center),
    .out_table_full    (out_table_full),
    .cmd               (cmd),
    .status            (status)
  );

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !status.out_busy)
    else $error("commit while output register occupied");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken during scan");

  a_new_not_seed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_new_center) |-> (out_cluster_label != '0))
    else $error("new center labeled as seed");

  a_new_xor_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_new_center && out_table_full))
    else $error("new center and table full together");

endmodule
